// ===== rtl/core/tvm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvm_pkg
// Shared types, opcodes and sizes for the toy VM execute core.
// ----------------------------------------------------------------------------
package tvm_pkg;

    localparam int DATA_WORDS_DEF    = 256;
    localparam int PROGRAM_WORDS_DEF = 512;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_EXP = 4'd4;
    localparam logic [3:0] OP_RED = 4'd5;
    localparam logic [3:0] OP_WRT = 4'd6;
    localparam logic [3:0] OP_STR = 4'd7;
    localparam logic [3:0] OP_JMP = 4'd8;
    localparam logic [3:0] OP_CJP = 4'd9;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [7:0]         dest_addr;
        logic [7:0]         src_a_addr;
        logic [7:0]         src_b_addr;
        logic signed [31:0] immediate_value;
        logic [8:0]         current_pc;
        logic signed [31:0] read_value;
    } instr_t;

    typedef struct packed {
        logic [9:0]         next_pc;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               divide_fault;
    } result_t;

    // classified instruction from front to back
    typedef struct packed {
        instr_t ins;
        logic   writes;   // arithmetic / read / store write dest
        logic   is_jump;
        logic   is_div;
    } decoded_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_RD_A, ST_RD_B, ST_RD_D, ST_MUL, ST_DIV,
        ST_WRITE, ST_RD_J, ST_JUMP, ST_OUT
    } exec_state_t;

endpackage

// ===== rtl/core/toy_vm_instruction_execute_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_vm_instruction_execute_core
// Execute unit of a small memory-to-memory VM: front end queues instruction
// beats, back end runs them against a 32-bit data memory.
// ----------------------------------------------------------------------------
// Channel   Ports                       Payload
// input     s_valid / s_ready / s_data  instr_t
// result    m_valid / m_ready / m_data  result_t
// config    cfg_we / cfg_wdata          program_length, 10 bits
//
// One instruction a time in the back end, set by the single RAM port.
// After reset a clearing pass zeroes the memory before any beat runs.
// The front queue holds two beats, so input is taken while a result
// waits on m_ready.
// ----------------------------------------------------------------------------
module toy_vm_instruction_execute_core
    import tvm_pkg::*;
#(
    parameter int DATA_WORDS    = DATA_WORDS_DEF,
    parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  instr_t     s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output result_t    m_data,
    input  logic       cfg_we,
    input  logic [9:0] cfg_wdata
);
    logic [9:0] prog_len_reg;
    logic       q_valid, q_pop;
    decoded_t   q_data;

    // program length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prog_len_reg <= '0;
        end else if (cfg_we) begin
            prog_len_reg <= cfg_wdata;
        end
    end

    tvm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
    );

    tvm_back #(.DATA_WORDS(DATA_WORDS), .PROGRAM_WORDS(PROGRAM_WORDS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .prog_len(prog_len_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

// ===== rtl/core/tvm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/tvm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvm_front
// Accepts instruction beats, classifies them, two-entry queue to back end.
// ----------------------------------------------------------------------------
module tvm_front
    import tvm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  instr_t   s_data,
    output logic     q_valid,
    input  logic     q_pop,
    output decoded_t q_data
);
    decoded_t q_reg [2];
    logic     rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    decoded_t dec;
    logic     push;

    always_comb begin
        dec = '0;
        dec.ins = s_data;
        unique case (s_data.opcode) inside
            OP_ADD, OP_SUB, OP_MUL, OP_EXP, OP_RED, OP_STR: dec.writes = 1'b1;
            OP_DIV: dec.is_div = 1'b1;
            OP_JMP, OP_CJP: dec.is_jump = 1'b1;
            default: ;
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= dec;
        end
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

// ===== rtl/core/tvm_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvm_divider
// Signed 32-bit radix-2 divider, truncating toward zero.
// ----------------------------------------------------------------------------
module tvm_divider
    import tvm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] quo_reg, den_reg;
    logic [32:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, neg_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted  = {rem_reg[31:0], quo_reg[31]};
    assign trial    = shifted - {1'b0, den_reg};
    assign done     = busy_reg && (cnt_reg == 6'd32);
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            quo_reg  <= dividend[31] ? (32'd0 - dividend) : dividend;
            den_reg  <= divisor[31] ? (32'd0 - divisor) : divisor;
            rem_reg  <= '0;
            neg_reg  <= dividend[31] ^ divisor[31];
        end else if (busy_reg) begin
            if (cnt_reg == 6'd32) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 6'd1;
                if (!trial[32]) begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
            end
        end
    end
endmodule

// ===== rtl/core/tvm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvm_back
// Executes classified instructions against the data memory.
// ----------------------------------------------------------------------------
module tvm_back
    import tvm_pkg::*;
#(
    parameter int DATA_WORDS    = DATA_WORDS_DEF,
    parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic [9:0] prog_len,
    input  logic     q_valid,
    output logic     q_pop,
    input  decoded_t q_data,
    output logic     m_valid,
    input  logic     m_ready,
    output result_t  m_data
);
    localparam int AW = $clog2(DATA_WORDS);
    // reciprocal for the address wrap; exact for 8-bit addresses
    localparam int ADDR_RECIP = (65536 + DATA_WORDS - 1) / DATA_WORDS;

    exec_state_t state_reg, state_next;
    decoded_t    cur_reg;
    logic [31:0] va_reg, vb_reg, wval_reg;
    logic [31:0] prod_reg;
    logic [AW-1:0] clr_reg;
    result_t     res_reg, res_next;
    logic        out_valid_reg;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic          div_start, div_done;
    logic [31:0]   div_q;
    logic [31:0]   arith;
    logic          take_jump;
    logic signed [11:0] target;
    logic [9:0]    limit;
    logic [9:0]    pc_inc;

    tvm_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr),
        .wdata(ram_wdata), .rdata(ram_rdata)
    );

    tvm_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(va_reg), .divisor(vb_reg), .done(div_done), .quotient(div_q)
    );

    // address modulo DATA_WORDS: quotient by reciprocal, then subtract
    function automatic logic [AW-1:0] wa(input logic [7:0] a);
        logic [31:0] prod;
        logic [31:0] rem;
        prod = 32'(a) * 32'(ADDR_RECIP);
        rem  = 32'(a) - 32'(prod[31:16]) * 32'(DATA_WORDS);
        return rem[AW-1:0];
    endfunction

    assign limit  = (32'(prog_len) > PROGRAM_WORDS) ? 10'(PROGRAM_WORDS) : prog_len;
    assign pc_inc = {1'b0, cur_reg.ins.current_pc} + 10'd1;
    assign target = $signed({3'b000, cur_reg.ins.current_pc}) + $signed(ram_rdata[11:0]);

    always_comb begin
        case (cur_reg.ins.opcode)
            OP_ADD:  arith = va_reg + vb_reg;
            OP_SUB:  arith = va_reg - vb_reg;
            OP_RED:  arith = cur_reg.ins.read_value;
            OP_STR:  arith = cur_reg.ins.immediate_value;
            default: arith = prod_reg;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == AW'(DATA_WORDS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (q_valid && !out_valid_reg) state_next = ST_RD_A;
            ST_RD_A:  state_next = ST_RD_B;
            ST_RD_B:  state_next = ST_RD_D;
            ST_RD_D: begin
                if (cur_reg.is_div) state_next = (vb_reg == 32'd0) ? ST_OUT : ST_DIV;
                else if (cur_reg.is_jump) state_next = ST_RD_J;
                else if (cur_reg.writes) state_next = ST_MUL;
                else state_next = ST_OUT;
            end
            ST_MUL:   state_next = ST_WRITE;
            ST_DIV:   if (div_done) state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            ST_RD_J:  state_next = ST_JUMP;
            ST_JUMP:  state_next = ST_IDLE;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = wa(cur_reg.ins.dest_addr);
        ram_wdata = wval_reg;
        div_start = 1'b0;
        q_pop     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1; ram_addr = clr_reg; ram_wdata = '0;
            end
            ST_IDLE: begin
                ram_addr = wa(q_data.ins.src_a_addr);
                q_pop    = q_valid && !out_valid_reg;
            end
            ST_RD_A:  ram_addr = wa(cur_reg.ins.src_b_addr);
            ST_RD_D:  div_start = cur_reg.is_div && (vb_reg != 32'd0);
            ST_WRITE: ram_we = 1'b1;
            default: ;
        endcase
    end

    assign take_jump = (cur_reg.ins.opcode == OP_JMP) || (va_reg == vb_reg);
    assign m_valid = out_valid_reg;
    assign m_data  = res_reg;

    // result word
    always_comb begin
        res_next = res_reg;
        unique case (state_reg)
            ST_WRITE: begin
                res_next         = '0;
                res_next.next_pc = pc_inc;
            end
            ST_OUT: begin
                res_next              = '0;
                res_next.next_pc      = pc_inc;
                res_next.divide_fault = cur_reg.is_div;
                res_next.print_valid  = (cur_reg.ins.opcode == OP_WRT);
                res_next.print_value  = (cur_reg.ins.opcode == OP_WRT) ? ram_rdata : 32'd0;
            end
            ST_JUMP: begin
                res_next = '0;
                // offset outside 12-bit span always lands out of range
                if (take_jump && (ram_rdata[31:11] == {21{ram_rdata[11]}}) &&
                    !target[11] && (target[10:0] <= {1'b0, limit}))
                    res_next.next_pc = 10'(target + 12'sd1);
                else
                    res_next.next_pc = pc_inc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + AW'(1);
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            if (state_reg == ST_WRITE || state_reg == ST_JUMP || state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
        end
        if (q_pop) cur_reg <= q_data;
        if (state_reg == ST_RD_A) va_reg <= ram_rdata;
        if (state_reg == ST_RD_B) vb_reg <= ram_rdata;
        if (state_reg == ST_MUL) wval_reg <= arith;
        if (state_reg == ST_DIV && div_done) wval_reg <= div_q;
        prod_reg <= (cur_reg.ins.opcode == OP_EXP) ? va_reg * va_reg : va_reg * vb_reg;
        res_reg  <= res_next;
    end
endmodule
